// ----- hdl/longest_unique_substring_core_assert.svh -----
// Assertion macros for the longest unique substring core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LONGEST_UNIQUE_SUBSTRING_CORE_ASSERT_SVH
`define LONGEST_UNIQUE_SUBSTRING_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LUS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LUS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lus_pkg.sv -----
// Shared types and constants for the longest unique substring core.
// No dependencies; imported by the top level and lus_window.
package lus_pkg;

    localparam int CHAR_BITS  = 8;
    localparam int CHAR_RANGE = 256;
    localparam int LEN_BITS   = 9;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 end_of_string;
    } char_item_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] best_length;
        logic                string_done;
        logic                overflow;
    } result_item_t;

    // Control from the pipeline to the window update stage.
    typedef struct packed {
        logic fire;
        logic last;
    } lus_step_t;

endpackage

// ----- hdl/longest_unique_substring_core.sv -----
// Longest substring without repeated bytes, one byte per transfer.
// Depends on lus_pkg, lus_pos_ram, lus_window and the assertion header.
//
// Usage:
//   Input channel char_valid/char_ready/char_item carries one byte and an
//   end-of-string mark. Output channel result_valid/result_ready/result_item
//   returns exactly one result per byte, in order: the best repeat-free
//   length so far in the string, the end mark, and a sticky overflow flag.
//   Flow: an accepted byte is registered into the processing stage and
//   its result into the output register. Throughput: one byte per cycle
//   while the output is not stalled. Each byte reads the last-position table
//   once when it is accepted and writes it once when processed; a repeat of
//   the byte just ahead of it is forwarded around the table.
//   Reset: seen bits, window start, position, best length and overflow clear
//   at once; the table itself is not cleared since an entry is only used
//   once its seen bit is set. No start-up delay.
//   End of string: after the marked byte, the string state clears so the
//   next byte begins a new string.
//   Stall: the output register holds its result while result_ready is low;
//   one more byte may wait in the processing stage, after which char_ready
//   drops until the result is taken.
module longest_unique_substring_core
    import lus_pkg::*;
#(
    parameter int ALPHABET = 256,
    parameter int POS_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_ready,
    input  char_item_t   char_item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_item
);

    localparam int CODE_BITS = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    logic [CODE_BITS-1:0] fold_lut [CHAR_RANGE];
    logic [CODE_BITS-1:0] in_code;
    logic                 char_fire;
    logic                 s1_fire;

    logic                 s1_valid_reg, s1_valid_next;
    logic [CODE_BITS-1:0] s1_code_reg;
    logic                 s1_last_reg;
    logic                 byp_reg, byp_next;
    logic [POS_BITS-1:0]  byp_pos_reg;
    logic                 res_valid_reg, res_valid_next;
    result_item_t         res_item_reg;

    logic [POS_BITS-1:0]  rd_pos;
    logic [POS_BITS-1:0]  prev_pos;
    logic [POS_BITS-1:0]  here;
    result_item_t         result;
    lus_step_t            step;

    // Codes beyond the alphabet fold back into it.
    for (genvar g = 0; g < CHAR_RANGE; g++)
    begin : g_fold
        assign fold_lut[g] = CODE_BITS'(g % ALPHABET);
    end

    assign in_code    = fold_lut[char_item.char_code];
    assign s1_fire    = s1_valid_reg && (!res_valid_reg || result_ready);
    assign char_ready = !s1_valid_reg || s1_fire;
    assign char_fire  = char_valid && char_ready;

    assign step.fire  = s1_fire;
    assign step.last  = s1_last_reg;

    // The table read at accept misses a write made at that same edge.
    assign prev_pos   = byp_reg ? byp_pos_reg : rd_pos;

    lus_pos_ram #(
        .DEPTH     (ALPHABET),
        .ADDR_BITS (CODE_BITS),
        .WIDTH     (POS_BITS)
    ) u_pos_ram (
        .clk     (clk),
        .rd_en   (char_fire),
        .rd_addr (in_code),
        .rd_data (rd_pos),
        .wr_en   (s1_fire),
        .wr_addr (s1_code_reg),
        .wr_data (here)
    );

    lus_window #(
        .ALPHABET  (ALPHABET),
        .POS_BITS  (POS_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .code     (s1_code_reg),
        .prev_pos (prev_pos),
        .here     (here),
        .result   (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        byp_next      = byp_reg;
        if (char_fire)
        begin
            s1_valid_next = 1'b1;
            byp_next      = s1_fire && (in_code == s1_code_reg);
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
            byp_next      = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            byp_reg       <= byp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_fire)
        begin
            s1_code_reg <= in_code;
            s1_last_reg <= char_item.end_of_string;
            byp_pos_reg <= here;
        end
        if (s1_fire)
        begin
            res_item_reg <= result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

`include "longest_unique_substring_core_assert.svh"

    `LUS_ASSERT_SAME(a_byp_needs_stage, byp_reg, s1_valid_reg, "bypass set with empty stage")
    `LUS_ASSERT_NEXT(a_fire_gives_result, s1_fire, res_valid_reg, "processed byte gave no result")
    `LUS_ASSERT_SAME(a_best_in_range, res_valid_reg, res_item_reg.best_length <= ALPHABET, "best length above alphabet size")
    `LUS_ASSERT_NEXT(a_byp_after_write, char_fire && s1_fire && (in_code == s1_code_reg), byp_reg, "same-code repeat not forwarded")

endmodule

// ----- hdl/lus_pos_ram.sv -----
// Last-position table: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module lus_pos_ram #(
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = 8,
    parameter int WIDTH     = 16
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read data holds while rd_en is low so a stalled reader keeps its value.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/lus_window.sv -----
// Window state and per-byte update: seen bits, window start, position, best length.
// Depends on lus_pkg; fed the previous position of the byte by the top level.
module lus_window
    import lus_pkg::*;
#(
    parameter int ALPHABET  = 256,
    parameter int POS_BITS  = 16,
    parameter int CODE_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lus_step_t            step,
    input  logic [CODE_BITS-1:0] code,
    input  logic [POS_BITS-1:0]  prev_pos,
    output logic [POS_BITS-1:0]  here,
    output result_item_t         result
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS:0]   LEN_CAP = (POS_BITS+1)'(ALPHABET);

    logic [ALPHABET-1:0] seen_valid_reg, seen_valid_next;
    logic [POS_BITS-1:0] ws_reg, ws_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [LEN_BITS-1:0] best_reg, best_next;
    logic                ovf_reg, ovf_next;

    logic                at_max;
    logic                hit;
    logic [POS_BITS-1:0] ws_hit;
    logic [POS_BITS-1:0] ws_new;
    logic [POS_BITS:0]   len_full;
    logic [POS_BITS:0]   len_cap;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] best_new;
    logic                ovf_new;
    logic [POS_BITS-1:0] pos_new;

    always_comb
    begin
        at_max = (pos_reg == POS_MAX);
        here   = pos_reg;
        // A repeat only counts if its earlier copy lies inside the window.
        hit    = seen_valid_reg[code] && (prev_pos >= ws_reg);
        ws_hit = (prev_pos == POS_MAX) ? POS_MAX : prev_pos + 1'b1;
        ws_new = hit ? ws_hit : ws_reg;
        if (ws_new > pos_reg)
        begin
            len_full = '0;
        end
        else
        begin
            len_full = {1'b0, pos_reg} - {1'b0, ws_new} + 1'b1;
        end
        len_cap  = (len_full > LEN_CAP) ? LEN_CAP : len_full;
        len      = len_cap[LEN_BITS-1:0];
        best_new = (len > best_reg) ? len : best_reg;
        ovf_new  = ovf_reg | at_max;
        pos_new  = at_max ? POS_MAX : pos_reg + 1'b1;

        result.best_length   = best_new;
        result.string_done   = step.last;
        result.overflow      = ovf_new;
    end

    always_comb
    begin
        seen_valid_next = seen_valid_reg;
        ws_next         = ws_reg;
        pos_next        = pos_reg;
        best_next       = best_reg;
        ovf_next        = ovf_reg;
        if (step.fire)
        begin
            if (step.last)
            begin
                seen_valid_next = '0;
                ws_next         = '0;
                pos_next        = '0;
                best_next       = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                seen_valid_next[code] = 1'b1;
                ws_next               = ws_new;
                pos_next              = pos_new;
                best_next             = best_new;
                ovf_next              = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_valid_reg <= '0;
            ws_reg         <= '0;
            pos_reg        <= '0;
            best_reg       <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            seen_valid_reg <= seen_valid_next;
            ws_reg         <= ws_next;
            pos_reg        <= pos_next;
            best_reg       <= best_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule
